/* design/bffa_pkg.sv */
`default_nettype none

package bffa_pkg;

    localparam int ENTRIES_DEF   = 4096;
    localparam int WORD_BITS_DEF = 64;

    localparam int SLOT_W  = 12;
    localparam int GRANT_W = 13;
    localparam int COUNT_W = 13;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_DUP   = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [GRANT_W-1:0] granted;
        logic [1:0]         status;
        logic [COUNT_W-1:0] free_left;
    } rsp_t;

    // Reset contents of map word w: one bit for each slot that exists.
    function automatic logic [63:0] word_mask(int w, int wb, int entries);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 64; i++)
        begin
            m[i] = (i < wb) && (w * wb + i < entries);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* design/bitmap_first_fit_allocator.sv */
`default_nettype none

// channel  valid      ready      payload                          role
// req      req_valid  req_ready  req  (opcode, slot)              allocate or free request
// rsp      rsp_valid  rsp_ready  rsp  (granted, status, free_left) one result per request
//
// A request steps through accept, word lookup and RAM read issue, read-modify-write of one
// map word, result handoff; a full map or out-of-range free skips the read-modify-write.
// The first free word comes from a per-word nonempty summary register, so no word scan.
// Reset needs no clearing pass: per-word written bits make unwritten words read as all free.
// A result waiting on rsp_ready holds the next request in its handoff cycle.

module bitmap_first_fit_allocator #(
    parameter int ENTRIES   = bffa_pkg::ENTRIES_DEF,
    parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire bffa_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output bffa_pkg::rsp_t      rsp
);

    import bffa_pkg::*;

    localparam int NUM_WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_RMW  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 op_reg, op_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [NUM_WORDS-1:0] written_reg, written_next;
    logic [NUM_WORDS-1:0] summary_reg, summary_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    rsp_t                 res_reg, res_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 ram_we, ram_re;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    logic [ADDR_W-1:0]    ram_raddr;

    logic [NUM_WORDS-1:0] sum_low;
    logic [ADDR_W-1:0]    first_word;
    logic [ADDR_W-1:0]    slot_word;
    logic                 slot_out;
    logic [63:0]          dflt_full;
    logic [WORD_BITS-1:0] word_q;
    logic [WORD_BITS-1:0] low_bit;
    logic [BIT_W-1:0]     low_idx;
    logic [WORD_BITS-1:0] free_bit;
    logic [CNT_W-1:0]     alloc_idx;

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // lowest nonempty word from the summary: isolate the low bit, then encode it
    always_comb
    begin
        sum_low    = summary_reg & (~summary_reg + 1'b1);
        first_word = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            first_word = first_word | (sum_low[i] ? ADDR_W'(i) : '0);
        end
    end

    assign slot_word = ADDR_W'(slot_reg >> BIT_W);
    assign slot_out  = int'(slot_reg) >= ENTRIES;
    assign dflt_full = word_mask(int'(addr_reg), WORD_BITS, ENTRIES);
    assign word_q    = written_reg[addr_reg] ? ram_rdata : dflt_full[WORD_BITS-1:0];
    assign free_bit  = WORD_BITS'(1) << slot_reg[BIT_W-1:0];

    always_comb
    begin
        low_bit = word_q & (~word_q + 1'b1);
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            low_idx = low_idx | (low_bit[i] ? BIT_W'(i) : '0);
        end
    end

    assign alloc_idx = (CNT_W'(addr_reg) << BIT_W) | CNT_W'(low_idx);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        addr_next      = addr_reg;
        written_next   = written_reg;
        summary_next   = summary_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = first_word;
        ram_wdata      = word_q & ~low_bit;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    slot_next  = req.slot;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (op_reg == OP_FREE)
                begin
                    if (slot_out)
                    begin
                        res_next   = '{GRANT_W'(slot_reg), ST_RANGE, COUNT_W'(cnt_reg)};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot_word;
                        addr_next  = slot_word;
                        state_next = S_RMW;
                    end
                end
                else if (summary_reg == '0)
                begin
                    res_next   = '{GRANT_W'(ENTRIES), ST_FULL, COUNT_W'(cnt_reg)};
                    state_next = S_FIN;
                end
                else
                begin
                    ram_re     = 1'b1;
                    addr_next  = first_word;
                    state_next = S_RMW;
                end
            end
            S_RMW:
            begin
                state_next = S_FIN;
                if (op_reg == OP_ALLOC)
                begin
                    ram_we                 = 1'b1;
                    written_next[addr_reg] = 1'b1;
                    summary_next[addr_reg] = (word_q & ~low_bit) != '0;
                    cnt_next               = cnt_reg - 1'b1;
                    res_next = '{GRANT_W'(alloc_idx), ST_OK, COUNT_W'(cnt_reg - 1'b1)};
                end
                else if ((word_q & free_bit) != '0)
                begin
                    res_next = '{GRANT_W'(slot_reg), ST_DUP, COUNT_W'(cnt_reg)};
                end
                else
                begin
                    ram_we                 = 1'b1;
                    ram_wdata              = word_q | free_bit;
                    written_next[addr_reg] = 1'b1;
                    summary_next[addr_reg] = 1'b1;
                    cnt_next               = cnt_reg + 1'b1;
                    res_next = '{GRANT_W'(slot_reg), ST_OK, COUNT_W'(cnt_reg + 1'b1)};
                end
            end
            S_FIN:
            begin
                // hold the result until the output register frees up
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            written_reg   <= '0;
            summary_reg   <= '1;
            cnt_reg       <= CNT_W'(ENTRIES);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            written_reg   <= written_next;
            summary_reg   <= summary_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        slot_reg <= slot_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= ENTRIES)
        else $error("free count above slot total");

    a_summary_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) == (summary_reg == '0))
        else $error("nonempty summary disagrees with free count");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_RMW)
        else $error("map write outside read-modify-write cycle");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_LOOK)
        else $error("accepted request did not start lookup");
`endif

endmodule

`default_nettype wire

/* design/bffa_ram.sv */
`default_nettype none

module bffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* tb/sv/bffa_checker.sv */
module bffa_checker #(
    parameter int ENTRIES   = bffa_pkg::ENTRIES_DEF,
    parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  bffa_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  bffa_pkg::rsp_t rsp,
    output int             fail_count,
    output int             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;

    localparam int N_WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;

    // A set bit marks a free slot.
    logic [63:0] slot_map [N_WORDS];
    int          free_count;
    int          fail_total;
    rsp_t        expected_rsp [$];

    function automatic rsp_t grant_or_release(input req_t r);
        rsp_t o;
        int   w;
        int   b;
        bit   found;
        o.granted   = GRANT_W'(ENTRIES);
        o.status    = ST_FULL;
        o.free_left = '0;
        found       = 1'b0;
        if (r.opcode == OP_ALLOC)
        begin
            for (w = 0; w < N_WORDS; w++)
            begin
                if (!found && slot_map[w] != '0)
                begin
                    b = 0;
                    while (!slot_map[w][b])
                        b++;
                    slot_map[w][b] = 1'b0;
                    if (free_count > 0)
                        free_count--;
                    o.granted = GRANT_W'(w * WORD_BITS + b);
                    o.status  = ST_OK;
                    found     = 1'b1;
                end
            end
        end
        else
        begin
            o.granted = GRANT_W'(r.slot);
            if (int'(r.slot) >= ENTRIES)
            begin
                o.status = ST_RANGE;
            end
            else
            begin
                w = int'(r.slot) / WORD_BITS;
                b = int'(r.slot) % WORD_BITS;
                if (slot_map[w][b])
                begin
                    o.status = ST_DUP;
                end
                else
                begin
                    slot_map[w][b] = 1'b1;
                    if (free_count < ENTRIES)
                        free_count++;
                    o.status = ST_OK;
                end
            end
        end
        o.free_left = COUNT_W'(free_count);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int w = 0; w < N_WORDS; w++)
            begin
                for (int b = 0; b < 64; b++)
                begin
                    slot_map[w][b] = (b < WORD_BITS) && (w * WORD_BITS + b < ENTRIES);
                end
            end
            free_count = ENTRIES;
            fail_total = 0;
            expected_rsp.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsp.push_back(grant_or_release(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    if (fail_total < 10)
                        $display("%0t: unexpected result beat: granted %0d status %0d left %0d",
                                 $realtime, rsp.granted, rsp.status, rsp.free_left);
                    fail_total++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.granted !== want.granted || rsp.status !== want.status ||
                        rsp.free_left !== want.free_left)
                    begin
                        if (fail_total < 10)
                            $display("%0t: expected granted %0d status %0d left %0d, got %0d %0d %0d",
                                     $realtime, want.granted, want.status, want.free_left,
                                     rsp.granted, rsp.status, rsp.free_left);
                        fail_total++;
                    end
                end
            end
            fail_count  <= fail_total;
            outstanding <= expected_rsp.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 95;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_ready = 1'b0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    int fail_count;
    int outstanding;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    bit hold_off_req = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bitmap_first_fit_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    bffa_checker alloc_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Offer one request beat; valid stays high into the next call unless a gap is drawn.
    task automatic issue(input logic op, input logic [SLOT_W-1:0] s);
        if ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        req_valid <= 1'b1;
        req       <= '{opcode: op, slot: s};
        do @(posedge clk); while (!req_ready);
    endtask

    // Hold the sender until every result has come back.
    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                rsp_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bitmap_first_fit_allocator: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int i;
        int phase;
        int alloc_pct;
        logic [SLOT_W-1:0] s;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Slot field is ignored on allocate.
        issue(OP_ALLOC, '1);
        issue(OP_ALLOC, '0);
        issue(OP_FREE, 12'd0);
        issue(OP_FREE, 12'd0);
        issue(OP_FREE, 12'hFFF);
        issue(OP_ALLOC, 12'h555);
        issue(OP_ALLOC, 12'hAAA);
        issue(OP_FREE, 12'd1);
        issue(OP_ALLOC, 12'd7);
        issue(OP_FREE, 12'd63);
        issue(OP_FREE, 12'd64);
        settle();

        // Top slot, a repeated free in the middle of the map, then a few allocations.
        issue(OP_FREE, 12'hFFF);
        issue(OP_FREE, 12'd0);
        issue(OP_FREE, 12'd2048);
        issue(OP_FREE, 12'd2048);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '1);
        settle();

        for (phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct      = 0;
                    stall_pct    = 63;
                    hold_off_req = 1'b1;
                end
                default:
                begin
                    gap_pct   = 18;
                    stall_pct = 18;
                end
            endcase
            alloc_pct = $urandom_range(35, 65);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                s = SLOT_W'($urandom);
                if ($urandom_range(99) < alloc_pct)
                begin
                    issue(OP_ALLOC, s);
                end
                else
                begin
                    // Low slots churn the most; freeing them twice hits the already-free case.
                    if ($urandom_range(3) == 0)
                        s = SLOT_W'($urandom_range(127));
                    issue(OP_FREE, s);
                end
            end
            settle();
        end

        repeat (16) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("bitmap_first_fit_allocator: match");
        else
            $display("bitmap_first_fit_allocator: mismatch");
        $finish;
    end

endmodule
